// ===== src/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants of the point rotate/project block
// Widths, register indexes, control struct and the quarter sine table builder.
// ----------------------------------------------------------------------------
package ppr_pkg;

    localparam int IO_W       = 16;   // port coordinate width
    localparam int DATA_W     = 22;   // internal coordinate width, holds all rotation growth
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int ANGLE_W    = 9;
    localparam int MAP_W      = 11;
    localparam int TILE_W     = 8;

    localparam int TAB_W      = 21;   // holds 2^frac for frac up to 20
    localparam int TAB_DEPTH  = 91;
    localparam int TAB_IDX_W  = 7;

    localparam int QUARTER_DEG = 90;
    localparam int HALF_DEG    = 180;
    localparam int THREE_Q_DEG = 270;
    localparam int FULL_DEG    = 360;
    localparam int ISO_DEG     = 30;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_X     = 3'd0,
        REG_ANGLE_Y     = 3'd1,
        REG_ANGLE_Z     = 3'd2,
        REG_ISO_MODE    = 3'd3,
        REG_MAP_COLUMNS = 3'd4,
        REG_MAP_ROWS    = 3'd5,
        REG_TILE_SIZE   = 3'd6
    } cfg_reg_t;

    typedef logic [TAB_W-1:0] sin_tab_t [TAB_DEPTH];

    typedef struct packed {
        logic                     iso_mode;
        logic signed [DATA_W-1:0] x_off;
        logic signed [DATA_W-1:0] y_off;
    } ppr_ctrl_t;

    // sin(d deg), d = 0..90, Taylor series in Q30, rounded to frac_bits.
    // Evaluated at elaboration only.
    function automatic sin_tab_t sine_table(input int unsigned frac_bits);
        sin_tab_t          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   r;
        longint            sum;
        for (int d = 0; d < TAB_DEPTH; d++) begin
            x    = (64'(d) * PI_Q30) / 64'(HALF_DEG);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 9; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) != 0)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = 0;
            r = (unsigned'(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
            if (r > (64'd1 << frac_bits))
                r = 64'd1 << frac_bits;
            tab[d] = r[TAB_W-1:0];
        end
        return tab;
    endfunction

endpackage

// ===== src/ppr_coef.sv =====
// ----------------------------------------------------------------------------
// ppr_coef: configuration registers and derived coefficients
// Holds the register file, turns angles into signed sine/cosine terms and
// computes the screen offsets for the final stage.
// ----------------------------------------------------------------------------
module ppr_coef #(
    parameter int TRIG_FRAC_BITS = 14,
    parameter int SCREEN_WIDTH   = 1920,
    parameter int SCREEN_HEIGHT  = 1080
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic signed [TRIG_FRAC_BITS+1:0]  sin_x,
    output logic signed [TRIG_FRAC_BITS+1:0]  cos_x,
    output logic signed [TRIG_FRAC_BITS+1:0]  sin_y,
    output logic signed [TRIG_FRAC_BITS+1:0]  cos_y,
    output logic signed [TRIG_FRAC_BITS+1:0]  sin_z,
    output logic signed [TRIG_FRAC_BITS+1:0]  cos_z,
    output ppr_pkg::ppr_ctrl_t                ctrl
);
    import ppr_pkg::*;

    localparam int       CW      = TRIG_FRAC_BITS + 2;
    localparam int       PROD_W  = MAP_W + TILE_W;
    localparam int       DIFF_W  = PROD_W + 2;
    localparam sin_tab_t SIN_TAB = sine_table(TRIG_FRAC_BITS);

    logic [ANGLE_W-1:0] angle_x_reg;
    logic [ANGLE_W-1:0] angle_y_reg;
    logic [ANGLE_W-1:0] angle_z_reg;
    logic               iso_mode_reg;
    logic [MAP_W-1:0]   map_columns_reg;
    logic [MAP_W-1:0]   map_rows_reg;
    logic [TILE_W-1:0]  tile_size_reg;

    logic signed [CW-1:0] sin_x_reg, cos_x_reg;
    logic signed [CW-1:0] sin_y_reg, cos_y_reg;
    logic signed [CW-1:0] sin_z_reg, cos_z_reg;

    logic [PROD_W-1:0]  prod_cols_reg;
    logic [PROD_W-1:0]  prod_rows_reg;
    logic signed [DIFF_W-1:0] x_diff, y_diff, x_bias, y_bias, x_half, y_half;
    ppr_ctrl_t          ctrl_next;
    ppr_ctrl_t          ctrl_reg;

    function automatic logic [ANGLE_W-1:0] reduce_angle(input logic [ANGLE_W-1:0] a);
        return (a >= ANGLE_W'(FULL_DEG)) ? a - ANGLE_W'(FULL_DEG) : a;
    endfunction

    // quadrant fold onto the 0..90 table
    function automatic logic signed [CW-1:0] sine_of(input logic [ANGLE_W-1:0] a);
        logic [TAB_IDX_W-1:0] idx;
        logic                 neg;
        logic [CW-1:0]        mag;
        if (a <= ANGLE_W'(QUARTER_DEG)) begin
            idx = TAB_IDX_W'(a);
            neg = 1'b0;
        end else if (a <= ANGLE_W'(HALF_DEG)) begin
            idx = TAB_IDX_W'(ANGLE_W'(HALF_DEG) - a);
            neg = 1'b0;
        end else if (a <= ANGLE_W'(THREE_Q_DEG)) begin
            idx = TAB_IDX_W'(a - ANGLE_W'(HALF_DEG));
            neg = 1'b1;
        end else begin
            idx = TAB_IDX_W'(ANGLE_W'(FULL_DEG) - a);
            neg = 1'b1;
        end
        mag = CW'(SIN_TAB[idx]);
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [CW-1:0] cosine_of(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] b;
        b = a + ANGLE_W'(QUARTER_DEG);
        if (b >= ANGLE_W'(FULL_DEG))
            b = b - ANGLE_W'(FULL_DEG);
        return sine_of(b);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg     <= '0;
            angle_y_reg     <= '0;
            angle_z_reg     <= '0;
            iso_mode_reg    <= 1'b1;
            map_columns_reg <= MAP_W'(1);
            map_rows_reg    <= MAP_W'(1);
            tile_size_reg   <= TILE_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ANGLE_X:     angle_x_reg     <= cfg_data[ANGLE_W-1:0];
                REG_ANGLE_Y:     angle_y_reg     <= cfg_data[ANGLE_W-1:0];
                REG_ANGLE_Z:     angle_z_reg     <= cfg_data[ANGLE_W-1:0];
                REG_ISO_MODE:    iso_mode_reg    <= cfg_data[0];
                REG_MAP_COLUMNS: map_columns_reg <= cfg_data[MAP_W-1:0];
                REG_MAP_ROWS:    map_rows_reg    <= cfg_data[MAP_W-1:0];
                REG_TILE_SIZE:   tile_size_reg   <= cfg_data[TILE_W-1:0];
                default:         ;
            endcase
        end
    end

    // coefficients are registered from the angle registers
    always_ff @(posedge clk)
    begin
        sin_x_reg <= sine_of(reduce_angle(angle_x_reg));
        cos_x_reg <= cosine_of(reduce_angle(angle_x_reg));
        sin_y_reg <= sine_of(reduce_angle(angle_y_reg));
        cos_y_reg <= cosine_of(reduce_angle(angle_y_reg));
        sin_z_reg <= sine_of(reduce_angle(angle_z_reg));
        cos_z_reg <= cosine_of(reduce_angle(angle_z_reg));
        prod_cols_reg <= PROD_W'(map_columns_reg) * PROD_W'(tile_size_reg);
        prod_rows_reg <= PROD_W'(map_rows_reg) * PROD_W'(tile_size_reg);
        ctrl_reg      <= ctrl_next;
    end

    // halving rounds toward zero
    always_comb
    begin
        x_diff = DIFF_W'(SCREEN_WIDTH) - DIFF_W'(prod_cols_reg);
        y_diff = DIFF_W'(SCREEN_HEIGHT) - DIFF_W'(prod_rows_reg);
        x_bias = x_diff + {{(DIFF_W-1){1'b0}}, x_diff[DIFF_W-1]};
        y_bias = y_diff + {{(DIFF_W-1){1'b0}}, y_diff[DIFF_W-1]};
        x_half = x_bias >>> 1;
        y_half = y_bias >>> 1;
        ctrl_next.iso_mode = iso_mode_reg;
        ctrl_next.x_off    = iso_mode_reg ? DATA_W'(SCREEN_WIDTH / 2) : DATA_W'(x_half);
        ctrl_next.y_off    = DATA_W'(y_half);
    end

    assign sin_x = sin_x_reg;
    assign cos_x = cos_x_reg;
    assign sin_y = sin_y_reg;
    assign cos_y = cos_y_reg;
    assign sin_z = sin_z_reg;
    assign cos_z = cos_z_reg;
    assign ctrl  = ctrl_reg;

endmodule

// ===== src/ppr_rot.sv =====
// ----------------------------------------------------------------------------
// ppr_rot: two-stage plane rotation unit
// a' = trunc((c*a - s*b) / 2^F), b' = trunc((s*a + c*b) / 2^F), p passes.
// ----------------------------------------------------------------------------
module ppr_rot #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_stall,
    input  logic signed [ppr_pkg::DATA_W-1:0] a_in,
    input  logic signed [ppr_pkg::DATA_W-1:0] b_in,
    input  logic signed [ppr_pkg::DATA_W-1:0] p_in,
    input  logic signed [FRAC_BITS+1:0]       sin_c,
    input  logic signed [FRAC_BITS+1:0]       cos_c,
    output logic                              dn_valid,
    input  logic                              dn_stall,
    output logic signed [ppr_pkg::DATA_W-1:0] a_out,
    output logic signed [ppr_pkg::DATA_W-1:0] b_out,
    output logic signed [ppr_pkg::DATA_W-1:0] p_out
);
    import ppr_pkg::*;

    localparam int CW = FRAC_BITS + 2;
    localparam int PW = DATA_W + CW;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] BIAS = SW'((64'd1 << FRAC_BITS) - 64'd1);

    logic [1:0] vld_reg;
    logic [1:0] rdy;

    logic signed [PW-1:0]     ca_reg, sb_reg, sa_reg, cb_reg;
    logic signed [DATA_W-1:0] p1_reg;
    logic signed [DATA_W-1:0] a_out_reg, b_out_reg, p_out_reg;

    function automatic logic signed [DATA_W-1:0] trunc_frac(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] biased;
        logic signed [SW-1:0] shifted;
        biased  = v + (v[SW-1] ? BIAS : '0);
        shifted = biased >>> FRAC_BITS;
        return shifted[DATA_W-1:0];
    endfunction

    always_comb
    begin
        rdy[1] = !vld_reg[1] || !dn_stall;
        rdy[0] = !vld_reg[0] || rdy[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= up_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && up_valid)
        begin
            ca_reg <= PW'(a_in) * PW'(cos_c);
            sb_reg <= PW'(b_in) * PW'(sin_c);
            sa_reg <= PW'(a_in) * PW'(sin_c);
            cb_reg <= PW'(b_in) * PW'(cos_c);
            p1_reg <= p_in;
        end
        if (rdy[1] && vld_reg[0])
        begin
            a_out_reg <= trunc_frac(SW'(ca_reg) - SW'(sb_reg));
            b_out_reg <= trunc_frac(SW'(sa_reg) + SW'(cb_reg));
            p_out_reg <= p1_reg;
        end
    end

    assign up_stall = !rdy[0];
    assign dn_valid = vld_reg[1];
    assign a_out    = a_out_reg;
    assign b_out    = b_out_reg;
    assign p_out    = p_out_reg;

endmodule

// ===== src/ppr_proj.sv =====
// ----------------------------------------------------------------------------
// ppr_proj: isometric projection, centering and output saturation
// Four stages: sum/difference, 30 degree multiply, truncate, offset + saturate.
// ----------------------------------------------------------------------------
module ppr_proj #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppr_pkg::ppr_ctrl_t                ctrl,
    input  logic                              up_valid,
    output logic                              up_stall,
    input  logic signed [ppr_pkg::DATA_W-1:0] x_rot,
    input  logic signed [ppr_pkg::DATA_W-1:0] y_rot,
    input  logic signed [ppr_pkg::DATA_W-1:0] z_rot,
    output logic                              dn_valid,
    input  logic                              dn_stall,
    output logic signed [ppr_pkg::IO_W-1:0]   x_out,
    output logic signed [ppr_pkg::IO_W-1:0]   y_out,
    output logic signed [ppr_pkg::IO_W-1:0]   z_out
);
    import ppr_pkg::*;

    localparam int       CW      = FRAC_BITS + 2;
    localparam int       DW1     = DATA_W + 1;
    localparam int       QP      = DW1 + CW;
    localparam int       QS      = QP + 1;
    localparam sin_tab_t SIN_TAB = sine_table(FRAC_BITS);
    localparam logic signed [CW-1:0] S30 = CW'(SIN_TAB[ISO_DEG]);
    localparam logic signed [CW-1:0] C30 = CW'(SIN_TAB[QUARTER_DEG - ISO_DEG]);
    localparam logic signed [QS-1:0] BIAS = QS'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [DW1-1:0] SAT_MAX = DW1'((1 <<< (IO_W - 1)) - 1);
    localparam logic signed [DW1-1:0] SAT_MIN = DW1'(-(1 <<< (IO_W - 1)));

    logic [3:0] vld_reg;
    logic [3:0] rdy;

    logic signed [DW1-1:0]    dif_reg, sum_reg;
    logic signed [DATA_W-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [QP-1:0]     pd_reg, ps_reg;
    logic signed [DATA_W-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [DATA_W-1:0] x3_reg, y3_reg, z3_reg;
    logic signed [DATA_W-1:0] x3_next, y3_next;
    logic signed [QS-1:0]     y_iso;
    logic signed [IO_W-1:0]   x_out_reg, y_out_reg, z_out_reg;

    function automatic logic signed [DATA_W-1:0] trunc_frac(input logic signed [QS-1:0] v);
        logic signed [QS-1:0] biased;
        logic signed [QS-1:0] shifted;
        biased  = v + (v[QS-1] ? BIAS : '0);
        shifted = biased >>> FRAC_BITS;
        return shifted[DATA_W-1:0];
    endfunction

    function automatic logic signed [IO_W-1:0] sat16(input logic signed [DW1-1:0] v);
        logic signed [DW1-1:0] c;
        if (v > SAT_MAX)
            c = SAT_MAX;
        else if (v < SAT_MIN)
            c = SAT_MIN;
        else
            c = v;
        return c[IO_W-1:0];
    endfunction

    always_comb
    begin
        rdy[3] = !vld_reg[3] || !dn_stall;
        for (int k = 2; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_comb
    begin
        y_iso   = QS'(ps_reg) - (QS'(z2_reg) <<< FRAC_BITS);
        x3_next = ctrl.iso_mode ? trunc_frac(QS'(pd_reg)) : x2_reg;
        y3_next = ctrl.iso_mode ? trunc_frac(y_iso) : y2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= up_valid;
            for (int k = 1; k < 4; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && up_valid)
        begin
            dif_reg <= DW1'(x_rot) - DW1'(y_rot);
            sum_reg <= DW1'(x_rot) + DW1'(y_rot);
            x1_reg  <= x_rot;
            y1_reg  <= y_rot;
            z1_reg  <= z_rot;
        end
        if (rdy[1] && vld_reg[0])
        begin
            pd_reg <= QP'(dif_reg) * QP'(C30);
            ps_reg <= QP'(sum_reg) * QP'(S30);
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            z2_reg <= z1_reg;
        end
        if (rdy[2] && vld_reg[1])
        begin
            x3_reg <= x3_next;
            y3_reg <= y3_next;
            z3_reg <= z2_reg;
        end
        if (rdy[3] && vld_reg[2])
        begin
            x_out_reg <= sat16(DW1'(x3_reg) + DW1'(ctrl.x_off));
            y_out_reg <= sat16(DW1'(y3_reg) + DW1'(ctrl.y_off));
            z_out_reg <= sat16(DW1'(z3_reg));
        end
    end

    assign up_stall = !rdy[0];
    assign dn_valid = vld_reg[3];
    assign x_out    = x_out_reg;
    assign y_out    = y_out_reg;
    assign z_out    = z_out_reg;

endmodule

// ===== src/point_rotate_project_top.sv =====
// ----------------------------------------------------------------------------
// point_rotate_project_top: 3D point rotation and isometric projection
// Rotates each point about X, Y, Z, then projects and centers it on screen.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake                  | Payload
//  --------+-----+----------------------------+----------------------------
//  point   | in  | point_valid / point_stall  | x_in, y_in, z_in
//  result  | out | result_valid / result_stall| x_out, y_out, z_out
//  config  | in  | cfg_write, no wait         | cfg_index, cfg_data
//
//  One request per clock while not stalled: input register, three rotation
//  units of two stages each (multiply, then sum and truncate), four stages of
//  projection and output. The rotation multipliers set the stage depth.
//  rst_n clears all valid bits and loads the register defaults at once.
//  Each stage holds while the next is full and held; empty stages keep filling
//  while a result waits, so point_stall rises only with the whole pipe full.
//  A config write takes effect for a request accepted on the next clock.
//
module point_rotate_project_top #(
    parameter int SCREEN_WIDTH   = 1920,
    parameter int SCREEN_HEIGHT  = 1080,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // point requests
    input  logic                              point_valid,
    output logic                              point_stall,
    input  logic signed [ppr_pkg::IO_W-1:0]   x_in,
    input  logic signed [ppr_pkg::IO_W-1:0]   y_in,
    input  logic signed [ppr_pkg::IO_W-1:0]   z_in,
    // results
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [ppr_pkg::IO_W-1:0]   x_out,
    output logic signed [ppr_pkg::IO_W-1:0]   y_out,
    output logic signed [ppr_pkg::IO_W-1:0]   z_out
);
    import ppr_pkg::*;

    localparam int CW = TRIG_FRAC_BITS + 2;

    // coefficients and control from the register file
    logic signed [CW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
    ppr_ctrl_t            ctrl;

    // input register
    logic                     in_vld_reg;
    logic                     in_rdy;
    logic signed [DATA_W-1:0] x0_reg, y0_reg, z0_reg;

    // between rotation units
    logic                     rx_stall, ry_stall, rz_stall, pj_stall;
    logic                     rx_valid, ry_valid, rz_valid;
    logic signed [DATA_W-1:0] x1, y1, z1;
    logic signed [DATA_W-1:0] x2, y2, z2;
    logic signed [DATA_W-1:0] x3, y3, z3;

    ppr_coef #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT)
    ) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sin_x     (sin_x),
        .cos_x     (cos_x),
        .sin_y     (sin_y),
        .cos_y     (cos_y),
        .sin_z     (sin_z),
        .cos_z     (cos_z),
        .ctrl      (ctrl)
    );

    // Input register: lets coefficients settle after a write and
    // cuts the port from the first multiplier.
    assign in_rdy      = !in_vld_reg || !rx_stall;
    assign point_stall = !in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_rdy)
            in_vld_reg <= point_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && point_valid)
        begin
            x0_reg <= DATA_W'(x_in);
            y0_reg <= DATA_W'(y_in);
            z0_reg <= DATA_W'(z_in);
        end
    end

    // about X: (y, z) rotate, x passes
    ppr_rot #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_vld_reg),
        .up_stall (rx_stall),
        .a_in     (y0_reg),
        .b_in     (z0_reg),
        .p_in     (x0_reg),
        .sin_c    (sin_x),
        .cos_c    (cos_x),
        .dn_valid (rx_valid),
        .dn_stall (ry_stall),
        .a_out    (y1),
        .b_out    (z1),
        .p_out    (x1)
    );

    // about Y: z' = c*z - s*x, x' = s*z + c*x
    ppr_rot #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rx_valid),
        .up_stall (ry_stall),
        .a_in     (z1),
        .b_in     (x1),
        .p_in     (y1),
        .sin_c    (sin_y),
        .cos_c    (cos_y),
        .dn_valid (ry_valid),
        .dn_stall (rz_stall),
        .a_out    (z2),
        .b_out    (x2),
        .p_out    (y2)
    );

    // about Z: (x, y) rotate, z passes
    ppr_rot #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ry_valid),
        .up_stall (rz_stall),
        .a_in     (x2),
        .b_in     (y2),
        .p_in     (z2),
        .sin_c    (sin_z),
        .cos_c    (cos_z),
        .dn_valid (rz_valid),
        .dn_stall (pj_stall),
        .a_out    (x3),
        .b_out    (y3),
        .p_out    (z3)
    );

    ppr_proj #(.FRAC_BITS(TRIG_FRAC_BITS)) u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .up_valid (rz_valid),
        .up_stall (pj_stall),
        .x_rot    (x3),
        .y_rot    (y3),
        .z_rot    (z3),
        .dn_valid (result_valid),
        .dn_stall (result_stall),
        .x_out    (x_out),
        .y_out    (y_out),
        .z_out    (z_out)
    );

endmodule

// ===== src/ppr_check.sv =====
// ----------------------------------------------------------------------------
// ppr_check: port-level checks for point_rotate_project_top
// Watches the request and result handshakes; bound to the top level below.
// ----------------------------------------------------------------------------
module ppr_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            point_valid,
    input logic                            point_stall,
    input logic                            result_valid,
    input logic                            result_stall,
    input logic signed [ppr_pkg::IO_W-1:0] x_out,
    input logic signed [ppr_pkg::IO_W-1:0] y_out,
    input logic signed [ppr_pkg::IO_W-1:0] z_out
);

    // a stalled result stays and holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(x_out)
            && $stable(y_out) && $stable(z_out))
        else $error("stalled result changed");

    // a result only leaves after it was taken
    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(!result_stall))
        else $error("result dropped while stalled");

    // bubbles collapse: requests stall only with a full pipe held at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> result_valid && result_stall)
        else $error("request stalled with room in the pipe");

    // reset empties the pipe and frees the request side by the next edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid && !point_stall)
        else $error("pipe not empty during reset");

    // a stalled request implies a result is waiting at the output
    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |-> result_valid)
        else $error("request stalled with no result pending");

endmodule

bind point_rotate_project_top ppr_check u_ppr_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .x_out        (x_out),
    .y_out        (y_out),
    .z_out        (z_out)
);

// ===== tb/sv/point_rotate_project_checker.sv =====
// ----------------------------------------------------------------------------
// point_rotate_project_checker: scoreboard for the point rotate/project block
// Mirrors the register file, predicts each screen point from the accepted
// request and compares it field by field with the results in arrival order.
// ----------------------------------------------------------------------------
module point_rotate_project_checker #(
    parameter int SCREEN_WIDTH   = 1920,
    parameter int SCREEN_HEIGHT  = 1080,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                point_valid,
    input  logic                                point_stall,
    input  logic signed [ppr_pkg::IO_W-1:0]     x_in,
    input  logic signed [ppr_pkg::IO_W-1:0]     y_in,
    input  logic signed [ppr_pkg::IO_W-1:0]     z_in,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic signed [ppr_pkg::IO_W-1:0]     x_out,
    input  logic signed [ppr_pkg::IO_W-1:0]     y_out,
    input  logic signed [ppr_pkg::IO_W-1:0]     z_out,
    output int                                  error_count,
    output int                                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppr_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [IO_W-1:0] x;
        logic signed [IO_W-1:0] y;
        logic signed [IO_W-1:0] z;
    } screen_point_t;

    localparam longint Q_ONE     = longint'(1) << TRIG_FRAC_BITS;
    localparam int     MAX_PRINT = 100;

    // register mirror
    logic [ANGLE_W-1:0] angle_x;
    logic [ANGLE_W-1:0] angle_y;
    logic [ANGLE_W-1:0] angle_z;
    logic               iso_on;
    logic [MAP_W-1:0]   map_cols;
    logic [MAP_W-1:0]   map_rows;
    logic [TILE_W-1:0]  tile_px;

    longint        sine_q [QUARTER_DEG+1];
    screen_point_t expected_points [$];
    screen_point_t oldest;
    int            mismatches = 0;

    assign error_count = mismatches;

    // Taylor series in Q30, rounded to the trig fraction width
    function automatic longint quarter_sine(int unsigned deg);
        u64_t   ang;
        u64_t   ang_sq;
        u64_t   term;
        u64_t   divisor;
        u64_t   rounded;
        longint acc;
        ang    = (u64_t'(deg) * PI_Q30) / u64_t'(HALF_DEG);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 9; n++) begin
            divisor = u64_t'((2 * n) * (2 * n + 1));
            term    = ((term * ang_sq) >> 30) / divisor;
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (u64_t'(acc) + (u64_t'(1) << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        if (rounded > (u64_t'(1) << TRIG_FRAC_BITS))
            rounded = u64_t'(1) << TRIG_FRAC_BITS;
        return longint'(rounded);
    endfunction

    initial
    begin
        for (int d = 0; d <= QUARTER_DEG; d++)
            sine_q[d] = quarter_sine(d);
    end

    function automatic longint sine_of(int unsigned a);
        if (a <= QUARTER_DEG)
            return sine_q[a];
        if (a <= HALF_DEG)
            return sine_q[HALF_DEG - a];
        if (a <= THREE_Q_DEG)
            return -sine_q[a - HALF_DEG];
        return -sine_q[FULL_DEG - a];
    endfunction

    function automatic longint cosine_of(int unsigned a);
        return sine_of((a + QUARTER_DEG) % FULL_DEG);
    endfunction

    // 9-bit register; 360..511 wraps once
    function automatic int unsigned fold_angle(logic [ANGLE_W-1:0] raw);
        int unsigned a;
        a = 32'(raw);
        if (a >= FULL_DEG)
            a = a - FULL_DEG;
        return a;
    endfunction

    // signed divide truncates toward zero
    function automatic longint scale_down(longint v);
        return v / Q_ONE;
    endfunction

    function automatic logic signed [IO_W-1:0] clamp16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[IO_W-1:0];
    endfunction

    function automatic screen_point_t project_point(logic signed [IO_W-1:0] xi,
                                                    logic signed [IO_W-1:0] yi,
                                                    logic signed [IO_W-1:0] zi);
        longint        x;
        longint        y;
        longint        z;
        longint        s;
        longint        c;
        longint        t;
        int unsigned   a;
        screen_point_t p;
        x = longint'(xi);
        y = longint'(yi);
        z = longint'(zi);

        a = fold_angle(angle_x);
        s = sine_of(a);
        c = cosine_of(a);
        t = y;
        y = scale_down(c * t - s * z);
        z = scale_down(s * t + c * z);

        a = fold_angle(angle_y);
        s = sine_of(a);
        c = cosine_of(a);
        t = x;
        x = scale_down(c * t + s * z);
        z = scale_down(c * z - s * t);

        a = fold_angle(angle_z);
        s = sine_of(a);
        c = cosine_of(a);
        t = x;
        x = scale_down(c * t - s * y);
        y = scale_down(s * t + c * y);

        if (iso_on)
        begin
            s = sine_of(ISO_DEG);
            c = cosine_of(ISO_DEG);
            t = x;
            x = scale_down((t - y) * c);
            y = scale_down(-z * Q_ONE + (t + y) * s);
            x = x + SCREEN_WIDTH / 2;
        end
        else
            x = x + (longint'(SCREEN_WIDTH) - longint'(map_cols) * longint'(tile_px)) / 2;
        y = y + (longint'(SCREEN_HEIGHT) - longint'(map_rows) * longint'(tile_px)) / 2;

        p.x = clamp16(x);
        p.y = clamp16(y);
        p.z = clamp16(z);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINT)
            $display("%0t ns checker: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x  = '0;
            angle_y  = '0;
            angle_z  = '0;
            iso_on   = 1'b1;
            map_cols = MAP_W'(1);
            map_rows = MAP_W'(1);
            tile_px  = TILE_W'(1);
            expected_points.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_points.size() == 0)
                    report_mismatch($sformatf("result (%0d, %0d, %0d) with no request pending",
                                              x_out, y_out, z_out));
                else
                begin
                    oldest = expected_points.pop_front();
                    if (x_out !== oldest.x)
                        report_mismatch($sformatf("x_out %0d, want %0d", x_out, oldest.x));
                    if (y_out !== oldest.y)
                        report_mismatch($sformatf("y_out %0d, want %0d", y_out, oldest.y));
                    if (z_out !== oldest.z)
                        report_mismatch($sformatf("z_out %0d, want %0d", z_out, oldest.z));
                end
            end
            // predict with the settings in force before this edge's write
            if (point_valid && !point_stall)
                expected_points.push_back(project_point(x_in, y_in, z_in));
            if (cfg_write)
                case (cfg_index)
                    REG_ANGLE_X:     angle_x  = cfg_data[ANGLE_W-1:0];
                    REG_ANGLE_Y:     angle_y  = cfg_data[ANGLE_W-1:0];
                    REG_ANGLE_Z:     angle_z  = cfg_data[ANGLE_W-1:0];
                    REG_ISO_MODE:    iso_on   = cfg_data[0];
                    REG_MAP_COLUMNS: map_cols = cfg_data[MAP_W-1:0];
                    REG_MAP_ROWS:    map_rows = cfg_data[MAP_W-1:0];
                    REG_TILE_SIZE:   tile_px  = cfg_data[TILE_W-1:0];
                    default: ;
                endcase
        end
        pending_count <= expected_points.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for point_rotate_project_top
// Drives point requests and register writes, shapes the result stall, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppr_pkg::*;

    localparam int SCREEN_W         = 1920;
    localparam int SCREEN_H         = 1080;
    localparam int FRAC_BITS        = 14;
    localparam int PIPE_LATENCY     = 11;
    localparam int RANDOM_PHASES    = 10;
    localparam int POINTS_PER_PHASE = 125;
    localparam int HOLD_PHASE       = 4;     // phase that gets the long result hold-off
    localparam int HOLD_CYCLES      = 120;   // far longer than the pipe depth
    localparam int CYCLE_LIMIT      = 400000;

    // index with no register behind it; writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // every input known from time zero
    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index    = '0;
    logic [CFG_DATA_W-1:0]     cfg_data     = '0;
    logic                      point_valid  = 1'b0;
    logic                      point_stall;
    logic signed [IO_W-1:0]    x_in         = '0;
    logic signed [IO_W-1:0]    y_in         = '0;
    logic signed [IO_W-1:0]    z_in         = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [IO_W-1:0]    x_out;
    logic signed [IO_W-1:0]    y_out;
    logic signed [IO_W-1:0]    z_out;

    int          error_count;
    int          pending_count;
    int unsigned cycle_count   = 0;

    // sender burst state
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // long hold-off handshake between stimulus and the receiver process
    int hold_requests = 0;
    int holds_served  = 0;

    point_rotate_project_top #(
        .SCREEN_WIDTH   (SCREEN_W),
        .SCREEN_HEIGHT  (SCREEN_H),
        .TRIG_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .x_in         (x_in),
        .y_in         (y_in),
        .z_in         (z_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .x_out        (x_out),
        .y_out        (y_out),
        .z_out        (z_out)
    );

    point_rotate_project_checker #(
        .SCREEN_WIDTH   (SCREEN_W),
        .SCREEN_HEIGHT  (SCREEN_H),
        .TRIG_FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .x_in          (x_in),
        .y_in          (y_in),
        .z_in          (z_in),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .x_out         (x_out),
        .y_out         (y_out),
        .z_out         (z_out),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog: a hung pipe or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern in random segments. Each segment picks a
    // duty (never, light, half, heavy) and a length, so stalls land on
    // every pipe phase and some stretches run with no stall at all.
    // A pending hold-off request is served at a segment boundary by
    // holding stall high through the hold-off; the sender keeps offering,
    // so the pipe fills and point_stall must rise.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        wait (rst_n);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    result_stall <= 1'b1;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       result_stall <= 1'b0;
                        1:       result_stall <= ($urandom_range(0, 3) == 0);
                        2:       result_stall <= 1'($urandom_range(0, 1));
                        default: result_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    // One register write per clock; caller lowers cfg_write afterwards.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Full register load, plus a write to the unused index. Only called
    // with the pipe drained and point_valid low.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] ax,
                                  input logic [CFG_DATA_W-1:0] ay,
                                  input logic [CFG_DATA_W-1:0] az,
                                  input logic                  iso,
                                  input logic [CFG_DATA_W-1:0] cols,
                                  input logic [CFG_DATA_W-1:0] rows,
                                  input logic [CFG_DATA_W-1:0] tile);
        logic [CFG_DATA_W-1:0] iso_word;
        iso_word    = CFG_DATA_W'($urandom);   // upper bits are don't-care
        iso_word[0] = iso;
        put_reg(REG_ANGLE_X, ax);
        put_reg(REG_ANGLE_Y, ay);
        put_reg(REG_ANGLE_Z, az);
        put_reg(REG_ISO_MODE, iso_word);
        put_reg(REG_MAP_COLUMNS, cols);
        put_reg(REG_MAP_ROWS, rows);
        put_reg(REG_TILE_SIZE, tile);
        put_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
    endtask

    // Offer one point request and hold it until accepted. Requests come in
    // bursts; an idle gap opens each new burst when enabled.
    task automatic send_point(input logic signed [IO_W-1:0] px,
                              input logic signed [IO_W-1:0] py,
                              input logic signed [IO_W-1:0] pz);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 8);
                point_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        point_valid <= 1'b1;
        x_in        <= px;
        y_in        <= py;
        z_in        <= pz;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait for every predicted result. The first edge
    // lets the checker's count take in the last accepted request.
    task automatic wait_drained();
        point_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // mostly map-sized values, some full range, some corners
    function automatic logic signed [IO_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return IO_W'(int'($urandom_range(0, 4000)) - 2000);
            6, 7, 8:          return IO_W'($urandom);
            default:
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
        endcase
    endfunction

    // angle in the low 9 bits, occasionally past 359; junk above
    function automatic logic [CFG_DATA_W-1:0] random_angle();
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            word[ANGLE_W-1:0] = ANGLE_W'($urandom_range(360, 511));
        else
            word[ANGLE_W-1:0] = ANGLE_W'($urandom_range(0, 359));
        return word;
    endfunction

    // map dimension, now and then zero or past 1024
    function automatic logic [CFG_DATA_W-1:0] random_span();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(1025, 2047));
            default: return CFG_DATA_W'($urandom_range(1, 1024));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_tile();
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            word[TILE_W-1:0] = '0;
        else
            word[TILE_W-1:0] = TILE_W'($urandom_range(1, 255));
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: no rotation, isometric, 1x1 map of 1 px tiles.
        // Coordinate corners push every stage toward saturation.
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd32767, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768);
        send_point(16'sd32767, -16'sd32768, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767, -16'sd32768);
        send_point(-16'sd1, 16'sd1, -16'sd1);
        wait_drained();

        // Angles at and past 359 (wrap by 360), plain centering with a
        // zero-width map and an oversized row count at the largest tile.
        apply_settings(11'd511, 11'd360, 11'd359, 1'b0, 11'd0, 11'd2047, 11'd255);
        send_point(16'sd100, -16'sd200, 16'sd50);
        send_point(16'sd32767, 16'sd0, -16'sd32768);
        send_point(-16'sd32768, -16'sd1, 16'sd32767);
        send_point(16'sd5, 16'sd5, 16'sd5);
        wait_drained();

        // Quadrant boundaries with the largest legal map.
        apply_settings(11'd90, 11'd180, 11'd270, 1'b1, 11'd1024, 11'd1024, 11'd255);
        send_point(16'sd1000, -16'sd1000, 16'sd300);
        send_point(16'sd32767, 16'sd32767, -16'sd32768);
        send_point(-16'sd32768, 16'sd0, 16'sd0);
        send_point(16'sd123, -16'sd456, 16'sd789);
        wait_drained();

        // Junk above the angle bits, zero tile size, plain mode.
        apply_settings({2'b11, 9'd45}, {2'b10, 9'd30}, {2'b01, 9'd315},
                       1'b0, 11'd1, 11'd1, {3'b111, 8'd0});
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd32767, -16'sd32768, 16'sd32767);
        send_point(-16'sd1, -16'sd1, -16'sd1);
        send_point(16'sd2000, -16'sd2000, 16'sd100);
        wait_drained();

        // All angles at 359, isometric, oversized columns, zero rows.
        apply_settings(11'd359, 11'd359, 11'd359, 1'b1, 11'd2047, 11'd0, 11'd1);
        send_point(16'sd32767, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768);
        send_point(16'sd7, -16'sd7, 16'sd7);

        // Random phases: fresh settings each, alternating projection mode.
        // Draining before each load doubles as the full-pause case.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            apply_settings(random_angle(), random_angle(), random_angle(),
                           (phase % 2) == 0, random_span(), random_span(), random_tile());
            gaps_on = (phase != HOLD_PHASE);
            if (phase == HOLD_PHASE)
                hold_requests++;
            repeat (POINTS_PER_PHASE)
                send_point(random_coord(), random_coord(), random_coord());
        end

        wait_drained();
        // quiet tail: any stray result shows up as unexpected
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/ppr_pkg.sv
src/ppr_coef.sv
src/ppr_rot.sv
src/ppr_proj.sv
src/point_rotate_project_top.sv
src/ppr_check.sv
tb/sv/point_rotate_project_checker.sv
tb/sv/tb_top.sv
